>>> rtl/core/rfp_pkg.sv
// rfp_pkg: shared types and constants of the relocation patcher
// relocation kinds, status codes, register indexes and field masks
// no dependencies
package rfp_pkg;

  localparam int unsigned SECTION_BYTES_DEF = 65536;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [3:0] {
    K_BRANCH       = 4'd0,
    K_JAL          = 4'd1,
    K_CALL         = 4'd2,
    K_PCREL_HI20   = 4'd3,
    K_PCREL_LO12_I = 4'd4,
    K_PCREL_LO12_S = 4'd5,
    K_HI20         = 4'd6,
    K_LO12_I       = 4'd7,
    K_LO12_S       = 4'd8,
    K_ABS32        = 4'd9,
    K_ADD32        = 4'd10,
    K_SUB32        = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BRANCH = 2'd1,
    ST_JUMP   = 2'd2,
    ST_BOUNDS = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE = 2'd0,
    REG_SIZE = 2'd1
  } reg_idx_t;

  localparam logic [31:0] BS_KEEP  = 32'h01FF_F07F;
  localparam logic [31:0] J_KEEP   = 32'h0000_0FFF;
  localparam logic [31:0] I_KEEP   = 32'h000F_FFFF;
  localparam logic [31:0] HI_ROUND = 32'h0000_0800;

endpackage

>>> rtl/core/riscv_fixup_patcher.sv
// riscv_fixup_patcher: three-stage pipelined risc-v relocation patcher
// depends on rfp_pkg for kinds, status codes and field masks
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  input     in_* fields                    start && !busy
//  result    out_* fields                   out_valid, one cycle, no backpressure
//  config    cfg_index, cfg_data            cfg_we
//
// a record enters every cycle while busy is low; its first result passes the stage 1, stage 2 and output registers
// a call whose jalr word lies in the section gives an auipc result and then a jalr result; busy is
// high while the first of them is shown, and the pipeline holds while busy is high
// stages: operand sum and bounds, delta and address adds, range check and field scatter
// synchronous active-low reset clears valid bits, configuration registers and the pending flag
module riscv_fixup_patcher #(
  parameter int unsigned SECTION_BYTES = rfp_pkg::SECTION_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     in_kind,
  input  logic [15:0]                    in_site_offset,
  input  logic [31:0]                    in_target_offset,
  input  logic signed [31:0]             in_addend,
  input  logic [15:0]                    in_anchor_offset,
  input  logic                           in_anchor_given,
  input  logic [31:0]                    in_site_word,
  input  logic [31:0]                    in_follow_word,
  input  logic                           cfg_we,
  input  logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic [31:0]                    out_patched_word,
  output logic                           out_word_select,
  output logic [1:0]                     out_status,
  output logic                           out_last
);
  import rfp_pkg::*;

  localparam int SZ_W = $clog2(SECTION_BYTES + 1);
  localparam int CW   = (SZ_W > 17) ? SZ_W : 17;

  localparam logic signed [33:0] BR_MIN = -34'sd4096;
  localparam logic signed [33:0] BR_MAX = 34'sd4094;
  localparam logic signed [33:0] J_MIN  = -34'sd1048576;
  localparam logic signed [33:0] J_MAX  = 34'sd1048574;

  typedef struct packed {
    logic        v;
    kind_t       kind;
    logic        oob;
    logic        pair;
    logic [33:0] sum;
    logic [15:0] site;
    logic [15:0] anc;
    logic [31:0] w0;
    logic [31:0] w1;
  } s1_t;

  typedef struct packed {
    logic        v;
    kind_t       kind;
    logic        oob;
    logic        pair;
    logic [33:0] delta;
    logic [31:0] rel;
    logic [31:0] lo;
    logic [31:0] abs;
    logic [31:0] w0;
    logic [31:0] w1;
  } s2_t;

  function automatic logic [31:0] put_b(input logic [31:0] w, input logic [31:0] v);
    return (w & BS_KEEP) | {v[12], v[10:5], 13'd0, v[4:1], v[11], 7'd0};
  endfunction

  function automatic logic [31:0] put_j(input logic [31:0] w, input logic [31:0] v);
    return (w & J_KEEP) | {v[20], v[10:1], v[11], v[19:12], 12'd0};
  endfunction

  function automatic logic [31:0] put_u(input logic [31:0] w, input logic [31:0] v);
    logic [31:0] r;
    r = v + HI_ROUND;
    return (w & J_KEEP) | {r[31:12], 12'd0};
  endfunction

  function automatic logic [31:0] put_i(input logic [31:0] w, input logic [31:0] v);
    return (w & I_KEEP) | {v[11:0], 20'd0};
  endfunction

  function automatic logic [31:0] put_s(input logic [31:0] w, input logic [31:0] v);
    return (w & BS_KEEP) | {v[11:5], 13'd0, v[4:0], 7'd0};
  endfunction

  logic [31:0]  base_r;
  logic [16:0]  size_r;
  logic [CW-1:0] size_ext, size_lim, eff_size, site4, site8;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;

  logic        adv;
  logic        br_bad, j_bad;
  logic [31:0] word_nxt;
  status_t     status_nxt;
  logic        last_nxt, pair_nxt;

  logic        out_valid_r, out_sel_r, out_last_r, pend_r;
  logic [31:0] out_word_r, pend_word_r;
  status_t     out_status_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE: base_r <= cfg_data;
        REG_SIZE: size_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign adv  = !pend_r;
  assign busy = pend_r;

  // stage 1: operand sum and bounds
  always_comb begin
    size_ext = CW'(size_r);
    size_lim = CW'(SECTION_BYTES);
    eff_size = (size_ext > size_lim) ? size_lim : size_ext;
    site4    = CW'(in_site_offset) + CW'(4);
    site8    = CW'(in_site_offset) + CW'(8);

    s1_nxt.v    = start;
    s1_nxt.kind = kind_t'(in_kind);
    s1_nxt.oob  = site4 > eff_size;
    s1_nxt.pair = site8 <= eff_size;
    s1_nxt.sum  = {2'b00, in_target_offset} + {{2{in_addend[31]}}, in_addend};
    s1_nxt.site = in_site_offset;
    s1_nxt.anc  = in_anchor_given ? in_anchor_offset : in_site_offset;
    s1_nxt.w0   = in_site_word;
    s1_nxt.w1   = in_follow_word;
  end

  // stage 2: delta and address adds
  always_comb begin
    s2_nxt.v     = s1_r.v;
    s2_nxt.kind  = s1_r.kind;
    s2_nxt.oob   = s1_r.oob;
    s2_nxt.pair  = s1_r.pair;
    s2_nxt.delta = s1_r.sum - {18'd0, s1_r.site};
    s2_nxt.rel   = s1_r.sum[31:0] - {16'd0, s1_r.site};
    s2_nxt.lo    = s1_r.sum[31:0] - {16'd0, s1_r.anc};
    s2_nxt.abs   = base_r + s1_r.sum[31:0];
    s2_nxt.w0    = s1_r.w0;
    s2_nxt.w1    = s1_r.w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.v <= 1'b0;
      s2_r.v <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  // stage 3: range check and field scatter
  always_comb begin
    br_bad = ($signed(s2_r.delta) < BR_MIN) || ($signed(s2_r.delta) > BR_MAX) ||
             s2_r.delta[0];
    j_bad  = ($signed(s2_r.delta) < J_MIN) || ($signed(s2_r.delta) > J_MAX) ||
             s2_r.delta[0];

    word_nxt   = s2_r.w0;
    status_nxt = ST_OK;
    last_nxt   = 1'b1;
    pair_nxt   = 1'b0;

    if (s2_r.oob) begin
      status_nxt = ST_BOUNDS;
    end else begin
      case (s2_r.kind)
        K_BRANCH: begin
          if (br_bad) status_nxt = ST_BRANCH;
          else        word_nxt   = put_b(s2_r.w0, s2_r.rel);
        end
        K_JAL: begin
          if (j_bad) status_nxt = ST_JUMP;
          else       word_nxt   = put_j(s2_r.w0, s2_r.rel);
        end
        K_CALL: begin
          word_nxt = put_u(s2_r.w0, s2_r.rel);
          last_nxt = !s2_r.pair;
          pair_nxt = s2_r.pair;
        end
        K_PCREL_HI20:   word_nxt = put_u(s2_r.w0, s2_r.rel);
        K_PCREL_LO12_I: word_nxt = put_i(s2_r.w0, s2_r.lo);
        K_PCREL_LO12_S: word_nxt = put_s(s2_r.w0, s2_r.lo);
        K_HI20:         word_nxt = put_u(s2_r.w0, s2_r.abs);
        K_LO12_I:       word_nxt = put_i(s2_r.w0, s2_r.abs);
        K_LO12_S:       word_nxt = put_s(s2_r.w0, s2_r.abs);
        K_ABS32:        word_nxt = s2_r.abs;
        default:        word_nxt = s2_r.w0;
      endcase
    end
  end

  // output register and pending jalr result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (pend_r) begin
      out_valid_r  <= 1'b1;
      out_word_r   <= pend_word_r;
      out_sel_r    <= 1'b1;
      out_status_r <= ST_OK;
      out_last_r   <= 1'b1;
      pend_r       <= 1'b0;
    end else begin
      out_valid_r  <= s2_r.v;
      out_word_r   <= word_nxt;
      out_sel_r    <= 1'b0;
      out_status_r <= status_nxt;
      out_last_r   <= last_nxt;
      pend_r       <= s2_r.v && pair_nxt;
      pend_word_r  <= put_i(s2_r.w1, s2_r.rel);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_patched_word = out_word_r;
  assign out_word_select  = out_sel_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

>>> rtl/core/rfp_checker.sv
// rfp_checker: port-level assertions for riscv_fixup_patcher
// depends on rfp_pkg for status codes; bound to the top level below
module rfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic       out_word_select,
  input logic [1:0] out_status,
  input logic       out_last
);
  import rfp_pkg::*;

  // busy only while the first half of a call pair is shown
  a_busy_first: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_valid && !out_last && !out_word_select)
    else $error("busy without first call result");

  // the jalr transaction follows the auipc one
  a_busy_second: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && out_last && out_word_select && out_status == ST_OK)
    else $error("missing second call result");

  a_second_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_select |-> $past(busy))
    else $error("follow word result without pending pair");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && !out_word_select)
    else $error("error result not a single site transaction");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind riscv_fixup_patcher rfp_checker u_rfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_word_select (out_word_select),
  .out_status      (out_status),
  .out_last        (out_last)
);
